/* rtl/kwm_pkg.sv */
// ---------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the divide-and-conquer k-way merge block.
// ---------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int RUN_W        = ADDR_W;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int SPLIT_DEPTH  = ADDR_W + 1;
    localparam int SP_W         = $clog2(SPLIT_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT  = 1'd1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_READ  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic                         operation;
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
        logic [ADDR_W-1:0]            read_index;
    } cmd_t;

    typedef struct packed {
        status_t                      status;
        logic signed [DATA_WIDTH-1:0] merged_value;
        logic [CNT_W-1:0]             total_count;
    } result_t;

    // Combine request from the split sequencer
    typedef struct packed {
        logic             go;
        logic [RUN_W-1:0] lo;
        logic [RUN_W-1:0] mid;
        logic [RUN_W-1:0] hi;
    } merge_req_t;

    // Element store access from the combine engine
    typedef struct packed {
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
    } elem_port_t;

endpackage

/* rtl/kwm_split.sv */
// ---------------------------------------------------------------------------
// kwm_split
// Split stack sequencer: walks the top-down run split in post order and
// issues one combine per internal node.
// ---------------------------------------------------------------------------
module kwm_split (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  logic [kwm_pkg::CFG_W-1:0] run_count,
    input  logic                    cdone,
    output kwm_pkg::merge_req_t     creq,
    output logic                    tree_done
);
    import kwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        PH_LEFT    = 2'd0,
        PH_RIGHT   = 2'd1,
        PH_COMBINE = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;

    logic [RUN_W-1:0] stk_lo [SPLIT_DEPTH];
    logic [RUN_W-1:0] stk_hi [SPLIT_DEPTH];
    phase_t           stk_ph [SPLIT_DEPTH];

    logic [SP_W-1:0]  top_idx;
    logic [RUN_W-1:0] t_lo, t_hi, t_mid;
    logic [RUN_W:0]   t_sum;
    phase_t           t_ph;

    logic             push_en;
    logic [RUN_W-1:0] push_lo, push_hi;
    logic             set_ph_en;
    phase_t           set_ph;

    assign top_idx = sp_reg - SP_W'(1);
    assign t_lo    = stk_lo[top_idx];
    assign t_hi    = stk_hi[top_idx];
    assign t_ph    = stk_ph[top_idx];
    assign t_sum   = {1'b0, t_lo} + {1'b0, t_hi};
    assign t_mid   = t_sum[RUN_W:1];

    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        push_en    = 1'b0;
        push_lo    = '0;
        push_hi    = '0;
        set_ph_en  = 1'b0;
        set_ph     = PH_LEFT;
        tree_done  = 1'b0;
        creq.go    = 1'b0;
        creq.lo    = t_lo;
        creq.mid   = t_mid;
        creq.hi    = t_hi;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    push_en    = 1'b1;
                    push_lo    = '0;
                    push_hi    = RUN_W'(run_count - CFG_W'(1));
                    sp_next    = SP_W'(1);
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (sp_reg == '0)
                begin
                    tree_done  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (t_lo >= t_hi)
                begin
                    sp_next = sp_reg - SP_W'(1);
                end
                else
                begin
                    case (t_ph)
                        PH_LEFT:
                        begin
                            set_ph_en = 1'b1;
                            set_ph    = PH_RIGHT;
                            push_en   = 1'b1;
                            push_lo   = t_lo;
                            push_hi   = t_mid;
                            sp_next   = sp_reg + SP_W'(1);
                        end
                        PH_RIGHT:
                        begin
                            set_ph_en = 1'b1;
                            set_ph    = PH_COMBINE;
                            push_en   = 1'b1;
                            push_lo   = t_mid + RUN_W'(1);
                            push_hi   = t_hi;
                            sp_next   = sp_reg + SP_W'(1);
                        end
                        PH_COMBINE:
                        begin
                            creq.go    = 1'b1;
                            state_next = S_WAIT;
                        end
                        default:
                        begin
                            sp_next = sp_reg - SP_W'(1);
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (cdone)
                begin
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = S_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stk_lo[sp_reg] <= push_lo;
            stk_hi[sp_reg] <= push_hi;
            stk_ph[sp_reg] <= PH_LEFT;
        end
        if (set_ph_en)
        begin
            stk_ph[top_idx] <= set_ph;
        end
    end

endmodule

/* rtl/kwm_combine.sv */
// ---------------------------------------------------------------------------
// kwm_combine
// Two-way merge engine: copies a run range to the scratch store, then merges
// the two halves back into the element store, one element per cycle.
// ---------------------------------------------------------------------------
module kwm_combine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kwm_pkg::merge_req_t            req,
    input  logic [kwm_pkg::CFG_W-1:0]      n,
    input  logic [kwm_pkg::DATA_WIDTH-1:0] elem_rdata,
    output kwm_pkg::elem_port_t            eport,
    output logic                           done
);
    import kwm_pkg::*;

    typedef enum logic [7:0] {
        C_IDLE  = 8'b0000_0001,
        C_START = 8'b0000_0010,
        C_SPLIT = 8'b0000_0100,
        C_END   = 8'b0000_1000,
        C_COPY  = 8'b0001_0000,
        C_FLUSH = 8'b0010_0000,
        C_PRIME = 8'b0100_0000,
        C_MERGE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RUN_W-1:0] lo_reg, lo_next;
    logic [RUN_W-1:0] mid_reg, mid_next;
    logic [RUN_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] split_reg, split_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;

    logic [DATA_WIDTH-1:0] scratch_mem [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] a_reg, b_reg;

    logic [CNT_W-1:0]       mul_a;
    logic [CNT_W+CFG_W-1:0] prod;
    logic                   take_left;

    // One shared multiplier for the three range bounds
    always_comb
    begin
        case (state_reg)
            C_START: mul_a = CNT_W'(lo_reg);
            C_SPLIT: mul_a = CNT_W'(mid_reg) + CNT_W'(1);
            C_END:   mul_a = CNT_W'(hi_reg) + CNT_W'(1);
            default: mul_a = '0;
        endcase
    end

    assign prod = mul_a * n;

    assign take_left = (j_reg == end_reg) ||
                       ((i_reg != split_reg) && ($signed(a_reg) < $signed(b_reg)));

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        start_next  = start_reg;
        split_next  = split_reg;
        end_next    = end_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = 1'b0;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        done        = 1'b0;
        eport.re    = 1'b0;
        eport.raddr = rd_ptr_reg[ADDR_W-1:0];
        eport.we    = 1'b0;
        eport.waddr = k_reg[ADDR_W-1:0];
        eport.wdata = take_left ? a_reg : b_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (req.go)
                begin
                    lo_next    = req.lo;
                    mid_next   = req.mid;
                    hi_next    = req.hi;
                    state_next = C_START;
                end
            end
            C_START:
            begin
                start_next = prod[CNT_W-1:0];
                state_next = C_SPLIT;
            end
            C_SPLIT:
            begin
                split_next = prod[CNT_W-1:0];
                state_next = C_END;
            end
            C_END:
            begin
                end_next    = prod[CNT_W-1:0];
                rd_ptr_next = start_reg;
                state_next  = C_COPY;
            end
            C_COPY:
            begin
                eport.re    = 1'b1;
                pend_next   = 1'b1;
                wr_ptr_next = rd_ptr_reg;
                rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                if (rd_ptr_next == end_reg)
                begin
                    state_next = C_FLUSH;
                end
            end
            C_FLUSH:
            begin
                // last copy write lands here; point the heads at both halves
                i_next     = start_reg;
                j_next     = split_reg;
                k_next     = start_reg;
                state_next = C_PRIME;
            end
            C_PRIME:
            begin
                state_next = C_MERGE;
            end
            C_MERGE:
            begin
                eport.we = 1'b1;
                if (take_left)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                k_next = k_reg + CNT_W'(1);
                if (k_next == end_reg)
                begin
                    done       = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        start_reg  <= start_next;
        split_reg  <= split_next;
        end_reg    <= end_next;
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
    end

    // Read at the next head positions so the heads are current every cycle
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            scratch_mem[wr_ptr_reg[ADDR_W-1:0]] <= elem_rdata;
        end
        a_reg <= scratch_mem[i_next[ADDR_W-1:0]];
        b_reg <= scratch_mem[j_next[ADDR_W-1:0]];
    end

endmodule

/* rtl/divide_conquer_kway_merge.sv */
// ---------------------------------------------------------------------------
// divide_conquer_kway_merge
// Loads sorted runs into an element store, merges them along a top-down
// split, and serves reads of the merged result.
// ---------------------------------------------------------------------------
// Reads and load errors answer in the cycle after the transfer.
// Items can follow one per cycle while busy is low.
// A matching final load holds busy for the merge: each combine copies its range to the
// scratch store and merges the two halves back, once per internal node of the split.
// Reset clears counters, flags and the split stack, sets both run registers to one
// and leaves the stores unset. The receiver cannot stall; done follows the merge.
module divide_conquer_kway_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  kwm_pkg::cmd_t                     cmd,
    output logic                              strobe,
    output kwm_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [kwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kwm_pkg::CFG_W-1:0]         cfg_data
);
    import kwm_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE  = 2'b01,
        T_MERGE = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] run_length_reg, run_count_reg;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic             merged_ready_reg, merged_ready_next;
    logic             go_reg, go_next;
    logic             strobe_reg, strobe_next;
    status_t          res_status_reg, res_status_next;
    logic [CNT_W-1:0] res_total_reg, res_total_next;
    logic             res_mem_reg, res_mem_next;

    logic [DATA_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] elem_rdata_reg;

    logic                  em_we, em_re;
    logic [ADDR_W-1:0]     em_waddr, em_raddr;
    logic [DATA_WIDTH-1:0] em_wdata;

    logic             accept, merging, full, read_ok;
    logic [CNT_W-1:0] lc_eff, lc_inc;
    logic [2*CFG_W-1:0] cfg_prod;

    merge_req_t creq;
    elem_port_t cport;
    logic       cdone, tree_done;

    kwm_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go_reg),
        .run_count (run_count_reg),
        .cdone     (cdone),
        .creq      (creq),
        .tree_done (tree_done)
    );

    kwm_combine u_combine (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (creq),
        .n          (run_length_reg),
        .elem_rdata (elem_rdata_reg),
        .eport      (cport),
        .done       (cdone)
    );

    assign merging  = (state_reg == T_MERGE);
    assign busy     = merging;
    assign accept   = start && !busy;
    assign lc_eff   = merged_ready_reg ? '0 : load_count_reg;
    assign lc_inc   = lc_eff + CNT_W'(1);
    assign full     = (lc_eff >= CNT_W'(MAX_ELEMENTS));
    assign cfg_prod = run_length_reg * run_count_reg;
    assign read_ok  = merged_ready_reg && ({1'b0, cmd.read_index} < load_count_reg);

    // Element store port: combine engine while merging, commands otherwise
    always_comb
    begin
        if (merging)
        begin
            em_we    = cport.we;
            em_waddr = cport.waddr;
            em_wdata = cport.wdata;
            em_re    = cport.re;
            em_raddr = cport.raddr;
        end
        else
        begin
            em_we    = accept && (cmd.operation == OP_LOAD) && !full;
            em_waddr = lc_eff[ADDR_W-1:0];
            em_wdata = cmd.value;
            em_re    = accept && (cmd.operation == OP_READ);
            em_raddr = cmd.read_index;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        load_count_next   = load_count_reg;
        merged_ready_next = merged_ready_reg;
        go_next           = 1'b0;
        strobe_next       = 1'b0;
        res_status_next   = ST_ERROR;
        res_total_next    = '0;
        res_mem_next      = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == OP_READ)
                    begin
                        strobe_next     = 1'b1;
                        res_status_next = read_ok ? ST_READ : ST_ERROR;
                        res_mem_next    = read_ok;
                    end
                    else
                    begin
                        merged_ready_next = 1'b0;
                        if (full)
                        begin
                            // drop the value
                            strobe_next     = 1'b1;
                            load_count_next = cmd.last ? '0 : lc_eff;
                        end
                        else if (!cmd.last)
                        begin
                            load_count_next = lc_inc;
                        end
                        else if ((2*CFG_W)'(lc_inc) != cfg_prod)
                        begin
                            strobe_next     = 1'b1;
                            load_count_next = '0;
                        end
                        else
                        begin
                            load_count_next   = lc_inc;
                            merged_ready_next = 1'b1;
                            go_next           = 1'b1;
                            state_next        = T_MERGE;
                        end
                    end
                end
            end
            T_MERGE:
            begin
                if (tree_done)
                begin
                    strobe_next     = 1'b1;
                    res_status_next = ST_DONE;
                    res_total_next  = load_count_reg;
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            run_length_reg   <= CFG_W'(1);
            run_count_reg    <= CFG_W'(1);
            load_count_reg   <= '0;
            merged_ready_reg <= 1'b0;
            go_reg           <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            merged_ready_reg <= merged_ready_next;
            go_reg           <= go_next;
            strobe_reg       <= strobe_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RUN_LENGTH: run_length_reg <= cfg_data;
                    CFG_RUN_COUNT:  run_count_reg  <= cfg_data;
                    default:        run_length_reg <= run_length_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
        res_mem_reg    <= res_mem_next;
    end

    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            elem_mem[em_waddr] <= em_wdata;
        end
        if (em_re)
        begin
            elem_rdata_reg <= elem_mem[em_raddr];
        end
    end

    assign strobe              = strobe_reg;
    assign result.status       = res_status_reg;
    assign result.merged_value = res_mem_reg ? elem_rdata_reg : '0;
    assign result.total_count  = res_total_reg;

endmodule
